// File: design/frame_quarter_turn_rotator_core_assert.svh
// Assertion macros used by the rotator back end.
`ifndef FRAME_QUARTER_TURN_ROTATOR_CORE_ASSERT_SVH
`define FRAME_QUARTER_TURN_ROTATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define FQTR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define FQTR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/fqtr_pkg.sv
// Shared types and constants of the frame quarter-turn rotator.
package fqtr_pkg;

  localparam int PIX_W        = 32;
  localparam int SIDE_W       = 7;
  localparam int TURN_W       = 2;
  localparam int IDX_W        = 2;
  localparam int MAX_SIDE_DEF = 64;
  localparam int CMD_DEPTH    = 2;
  localparam int OUT_DEPTH    = 2;

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [TURN_W-1:0] turn_t;
  typedef logic [IDX_W-1:0]  reg_idx_t;

  localparam reg_idx_t REG_WIDTH  = 2'd0;
  localparam reg_idx_t REG_HEIGHT = 2'd1;
  localparam reg_idx_t REG_TURN   = 2'd2;

  localparam turn_t TURN_0   = 2'd0;
  localparam turn_t TURN_90  = 2'd1;
  localparam turn_t TURN_180 = 2'd2;
  localparam turn_t TURN_270 = 2'd3;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EMIT = 1'b1;

  localparam side_t SIDE_RST = 7'd64;

endpackage

// File: design/fqtr_fifo.sv
// Small register-based FIFO used between rotator stages.
module fqtr_fifo #(
  parameter int W     = 1,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [W-1:0]                 wr_data,
  output logic                         full,
  input  logic                         rd_en,
  output logic [W-1:0]                 rd_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic          wr_fire;
  logic          rd_fire;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign wr_fire = wr_en && !full;
  assign rd_fire = rd_en && !empty;
  assign rd_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      slot[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_fire) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_fire) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(wr_fire) - CW'(rd_fire);
    end
  end

endmodule

// File: design/fqtr_front.sv
// Front end: config registers, load/emit counters and store address generation.
module fqtr_front #(
  parameter int MAX_SIDE = fqtr_pkg::MAX_SIDE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  fqtr_pkg::reg_idx_t   cfg_index,
  input  fqtr_pkg::side_t      cfg_data,
  input  logic                 push,
  input  logic                 mode,
  input  fqtr_pkg::pixel_t     pixel_in,
  input  logic                 cmd_full,
  output logic                 cmd_wr,
  output logic                 cmd_rd,
  output logic                 cmd_last,
  output logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE*MAX_SIDE) : 1)-1:0] cmd_addr,
  output fqtr_pkg::pixel_t     cmd_data
);

  import fqtr_pkg::*;

  localparam int SIDE_CAP = (1 << SIDE_W) - 1;
  localparam int SIDE_LIM = (MAX_SIDE < SIDE_CAP) ? MAX_SIDE : SIDE_CAP;
  localparam int CW       = (SIDE_LIM > 1) ? $clog2(SIDE_LIM) : 1;
  localparam int AW       = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;
  localparam int PW       = 2 * SIDE_W;
  localparam int MW       = (AW > PW) ? AW : PW;

  side_t         frame_width;
  side_t         frame_height;
  turn_t         turn;
  logic [AW-1:0] load_count;
  logic [AW-1:0] load_count_next;
  logic [CW-1:0] out_col;
  logic [CW-1:0] out_row;
  logic [CW-1:0] out_col_next;
  logic [CW-1:0] out_row_next;

  side_t         w, h, ow, oh;
  side_t         xs, ys, sx, sy;
  logic [CW-1:0] x, y;
  logic [PW-1:0] size;
  logic [MW-1:0] ld_base;
  logic [MW-1:0] ld_inc;
  logic [PW-1:0] lin;
  logic [MW-1:0] rd_idx;
  logic          swaps;
  logic          wrap;
  logic          x_end;
  logic          y_end;
  logic          accept;

  function automatic side_t clamp_side(input side_t v);
    side_t r;
    if (v == '0) begin
      r = side_t'(1);
    end else if (v > side_t'(SIDE_LIM)) begin
      r = side_t'(SIDE_LIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign accept    = push && !cmd_full;

  always_comb begin
    w     = clamp_side(frame_width);
    h     = clamp_side(frame_height);
    size  = PW'(w) * PW'(h);
    swaps = (turn == TURN_90) || (turn == TURN_270);
    ow    = swaps ? h : w;
    oh    = swaps ? w : h;

    // load side: restart past frame end, then post-increment with wrap
    ld_base = (MW'(load_count) >= MW'(size)) ? '0 : MW'(load_count);
    ld_inc  = ld_base + MW'(1);
    load_count_next = (ld_inc >= MW'(size)) ? '0 : ld_inc[AW-1:0];

    // emit side
    wrap = (side_t'(out_col) >= ow) || (side_t'(out_row) >= oh);
    x    = wrap ? '0 : out_col;
    y    = wrap ? '0 : out_row;
    xs   = side_t'(x);
    ys   = side_t'(y);

    case (turn)
      TURN_90: begin
        sx = ys;
        sy = h - 1'b1 - xs;
      end
      TURN_180: begin
        sx = w - 1'b1 - xs;
        sy = h - 1'b1 - ys;
      end
      TURN_270: begin
        sx = w - 1'b1 - ys;
        sy = xs;
      end
      default: begin
        sx = xs;
        sy = ys;
      end
    endcase

    lin    = PW'(sy) * PW'(w) + PW'(sx);
    rd_idx = MW'(lin);

    x_end = (xs == ow - 1'b1);
    y_end = (ys == oh - 1'b1);
    if (x_end) begin
      out_col_next = '0;
      out_row_next = y_end ? '0 : y + 1'b1;
    end else begin
      out_col_next = x + 1'b1;
      out_row_next = y;
    end
  end

  assign cmd_wr   = accept;
  assign cmd_rd   = (mode == MODE_EMIT);
  assign cmd_last = (mode == MODE_EMIT) && x_end && y_end;
  assign cmd_addr = (mode == MODE_EMIT) ? rd_idx[AW-1:0] : ld_base[AW-1:0];
  assign cmd_data = pixel_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= SIDE_RST;
      frame_height <= SIDE_RST;
      turn         <= TURN_0;
      load_count   <= '0;
      out_col      <= '0;
      out_row      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIDTH:  frame_width  <= cfg_data;
          REG_HEIGHT: frame_height <= cfg_data;
          REG_TURN:   turn         <= cfg_data[TURN_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        if (mode == MODE_EMIT) begin
          out_col <= out_col_next;
          out_row <= out_row_next;
        end else begin
          load_count <= load_count_next;
        end
      end
    end
  end

endmodule

// File: design/fqtr_back.sv
// Back end: frame store access and result queue.
`include "frame_quarter_turn_rotator_core_assert.svh"

module fqtr_back #(
  parameter int MAX_SIDE = fqtr_pkg::MAX_SIDE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  input  logic              cmd_rd,
  input  logic              cmd_last,
  input  logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE*MAX_SIDE) : 1)-1:0] cmd_addr,
  input  fqtr_pkg::pixel_t  cmd_data,
  input  logic              pop,
  output logic              empty,
  output fqtr_pkg::pixel_t  pixel_out,
  output logic              last
);

  import fqtr_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int OCW   = $clog2(OUT_DEPTH + 1);
  localparam int OW    = OCW + 1;

  pixel_t           store [DEPTH];
  pixel_t           mem_q;
  logic             last_q;
  logic             rd_valid;
  logic             issue;
  logic             room;
  logic             pop_fire;
  logic             out_full;
  logic [OCW-1:0]   out_count;
  logic [OW-1:0]    occ;
  logic [PIX_W:0]   out_word;

  // slots taken once the read issued now has landed
  assign pop_fire = pop && !empty;
  assign occ      = OW'(out_count) + OW'(rd_valid) + OW'(1) - OW'(pop_fire);
  assign room     = (occ <= OW'(OUT_DEPTH));
  assign issue    = !cmd_empty && (!cmd_rd || room);
  assign cmd_pop  = issue;

  always_ff @(posedge clk) begin
    if (issue && !cmd_rd) begin
      store[cmd_addr] <= cmd_data;
    end
    if (issue && cmd_rd) begin
      mem_q  <= store[cmd_addr];
      last_q <= cmd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue && cmd_rd;
    end
  end

  fqtr_fifo #(
    .W     (PIX_W + 1),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rd_valid),
    .wr_data ({last_q, mem_q}),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_word),
    .empty   (empty),
    .count   (out_count)
  );

  assign pixel_out = out_word[PIX_W-1:0];
  assign last      = out_word[PIX_W];

  `FQTR_ASSERT_IMP(a_out_no_overflow, rd_valid, !out_full || pop, "result queue overflow")
  `FQTR_ASSERT_NXT(a_read_lands, issue && cmd_rd, rd_valid, "store read lost")
  `FQTR_ASSERT_NXT(a_idle_stays_empty, empty && !rd_valid && !(issue && cmd_rd), empty,
    "result appeared without a read")

endmodule

// File: design/frame_quarter_turn_rotator_core.sv
// Top level of the frame quarter-turn rotator.
//
//   channel   direction  handshake          payload
//   input     in         push / full        mode, pixel_in
//   result    out        empty / pop        pixel_out, last
//   config    in         cfg_valid/ready    cfg_index, cfg_data
//
// One item per cycle while results are popped; each item is one frame store access
// in the back end. An emit's result passes the command queue, store read register and
// result queue to the ports. Loads give no result. A stalled result queue backs up emits
// into the command queue, which then raises full; further items are taken until it fills.
// Reset zeroes counters and turn, sets both sides to 64; the store has no reset, needs none.
module frame_quarter_turn_rotator_core #(
  parameter int MAX_SIDE = fqtr_pkg::MAX_SIDE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                mode,
  input  fqtr_pkg::pixel_t    pixel_in,
  output logic                empty,
  input  logic                pop,
  output fqtr_pkg::pixel_t    pixel_out,
  output logic                last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  fqtr_pkg::reg_idx_t  cfg_index,
  input  fqtr_pkg::side_t     cfg_data
);

  import fqtr_pkg::*;

  localparam int AW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;
  localparam int CMDW = 2 + AW + PIX_W;

  logic            fe_wr;
  logic            fe_rd;
  logic            fe_last;
  logic [AW-1:0]   fe_addr;
  pixel_t          fe_data;
  logic            cmd_empty;
  logic            cmd_pop;
  logic [CMDW-1:0] cmd_word;

  fqtr_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .mode      (mode),
    .pixel_in  (pixel_in),
    .cmd_full  (full),
    .cmd_wr    (fe_wr),
    .cmd_rd    (fe_rd),
    .cmd_last  (fe_last),
    .cmd_addr  (fe_addr),
    .cmd_data  (fe_data)
  );

  fqtr_fifo #(
    .W     (CMDW),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fe_wr),
    .wr_data ({fe_rd, fe_last, fe_addr, fe_data}),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_word),
    .empty   (cmd_empty),
    .count   ()
  );

  fqtr_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd_rd    (cmd_word[CMDW-1]),
    .cmd_last  (cmd_word[CMDW-2]),
    .cmd_addr  (cmd_word[PIX_W+AW-1:PIX_W]),
    .cmd_data  (cmd_word[PIX_W-1:0]),
    .pop       (pop),
    .empty     (empty),
    .pixel_out (pixel_out),
    .last      (last)
  );

endmodule
